// ----- sv/apct_pkg.sv -----
// Package with the shared types and constants of the box pair contact tracker.
`timescale 1ns / 1ps

package apct_pkg;

    // Default identifier width; the contact table holds one bit per ordered pair.
    localparam int ID_BITS_DEF = 6;

    // Widths of the fields in a pair transaction.
    localparam int ID_W    = 6;
    localparam int COORD_W = 16;
    localparam int SIZE_W  = 16;

    typedef enum logic [1:0] {
        EV_NONE  = 2'd0,
        EV_ENTER = 2'd1,
        EV_STAY  = 2'd2,
        EV_EXIT  = 2'd3
    } t_event;

    typedef enum logic {
        ST_CLEAR = 1'b0,
        ST_RUN   = 1'b1
    } t_state;

    typedef struct packed {
        logic [ID_W-1:0]           first_id;
        logic [ID_W-1:0]           second_id;
        logic signed [COORD_W-1:0] first_x;
        logic signed [COORD_W-1:0] first_y;
        logic [SIZE_W-1:0]         first_w;
        logic [SIZE_W-1:0]         first_h;
        logic signed [COORD_W-1:0] second_x;
        logic signed [COORD_W-1:0] second_y;
        logic [SIZE_W-1:0]         second_w;
        logic [SIZE_W-1:0]         second_h;
    } t_pair;

    typedef struct packed {
        t_event contact_event;
        logic   overlapping;
    } t_result;

endpackage

// ----- sv/aabb_pair_contact_tracker.sv -----
// Top level of the box pair contact tracker: overlap test and contact table update.
`timescale 1ns / 1ps

// Each input transaction on i_pair carries an ordered pair of collider
// identifiers with the center and full size of both boxes. The block tests
// the two boxes for overlap on both axes and compares the result with the
// stored contact bit of that ordered pair, reporting enter, stay, exit or
// none on o_result together with the current overlap flag.
// Both channels use valid and stall; a transaction moves at a rising edge
// where valid is high and stall is low.
// A pair accepted at an edge goes to the compare stage, then its result to
// the output register that drives o_valid. One pair can be accepted every
// cycle while the receiver does not stall: the contact bit is read from the
// table RAM at the accept edge, written back as the pair leaves the compare
// stage; a one-entry forward register covers a read of the entry being written.
// While the receiver stalls, the result holds in the output register, one
// more pair waits in the compare stage, and o_stall rises after that.
// After reset the table is cleared by a pass that writes one entry per
// cycle over all 2**(2*ID_BITS) entries (4096 at the default); o_stall stays
// high during that pass.

module aabb_pair_contact_tracker
    import apct_pkg::*;
#(
    parameter int ID_BITS = ID_BITS_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_stall,
    input  t_pair   i_pair,
    output logic    o_valid,
    input  logic    i_stall,
    output t_result o_result
);

    localparam int ADDR_W = 2 * ID_BITS;
    localparam int DEPTH  = 1 << ADDR_W;
    localparam int EXT_W  = COORD_W + 1;

    // Clearing sequencer.
    t_state            r_state;
    t_state            n_state;
    logic [ADDR_W-1:0] r_clr_addr;
    logic [ADDR_W-1:0] n_clr_addr;
    logic              clearing;

    // Compare stage, loaded at the accept edge while the RAM is read.
    logic                    r_s1_valid;
    logic [ADDR_W-1:0]       r_s1_addr;
    logic signed [EXT_W-1:0] r_s1_dx;
    logic signed [EXT_W-1:0] r_s1_dy;
    logic [EXT_W-1:0]        r_s1_sx;
    logic [EXT_W-1:0]        r_s1_sy;
    logic                    r_fwd_hit;
    logic                    r_fwd_bit;

    // Output register.
    logic    r_o_valid;
    t_result r_o_result;

    logic                    in_accept;
    logic                    s1_adv;
    logic [ADDR_W-1:0]       in_addr;
    logic signed [EXT_W-1:0] dx;
    logic signed [EXT_W-1:0] dy;
    logic [EXT_W-1:0]        sx;
    logic [EXT_W-1:0]        sy;
    logic [EXT_W-1:0]        abs_x;
    logic [EXT_W-1:0]        abs_y;
    logic [EXT_W-1:0]        dbl_x;
    logic [EXT_W-1:0]        dbl_y;
    logic                    hit;
    logic                    was;
    t_event                  ev;
    logic                    ram_we;
    logic [ADDR_W-1:0]       ram_waddr;
    logic [0:0]              ram_wdata;
    logic [0:0]              ram_rdata;

    // Next state of the clearing sequencer.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (r_clr_addr == {ADDR_W{1'b1}}) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                n_state = ST_RUN;
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    // Outputs of the clearing sequencer.
    always_comb begin
        clearing   = 1'b0;
        n_clr_addr = r_clr_addr;
        unique case (r_state)
            ST_CLEAR: begin
                clearing   = 1'b1;
                n_clr_addr = ADDR_W'(r_clr_addr + 1'b1);
            end
            ST_RUN: begin
                clearing = 1'b0;
            end
            default: begin
                clearing = 1'b1;
            end
        endcase
    end

    // Handshake. The compare stage moves on whenever the output register is
    // empty or is being taken, and a new pair enters behind it in the same cycle.
    assign s1_adv    = r_s1_valid && (!r_o_valid || !i_stall);
    assign o_stall   = clearing || (r_s1_valid && !s1_adv);
    assign in_accept = i_valid && !o_stall;

    // The table index is first_id above second_id, each cut or widened to ID_BITS.
    assign in_addr = {ID_BITS'(i_pair.first_id), ID_BITS'(i_pair.second_id)};

    // Differences and size sums at one bit more than the fields, so nothing wraps.
    assign dx = EXT_W'(signed'({i_pair.first_x[COORD_W-1], i_pair.first_x}))
              - EXT_W'(signed'({i_pair.second_x[COORD_W-1], i_pair.second_x}));
    assign dy = EXT_W'(signed'({i_pair.first_y[COORD_W-1], i_pair.first_y}))
              - EXT_W'(signed'({i_pair.second_y[COORD_W-1], i_pair.second_y}));
    assign sx = {1'b0, i_pair.first_w} + {1'b0, i_pair.second_w};
    assign sy = {1'b0, i_pair.first_h} + {1'b0, i_pair.second_h};

    // The magnitude of a difference fits in COORD_W bits, so doubling it
    // never overflows EXT_W bits.
    assign abs_x = r_s1_dx[EXT_W-1] ? EXT_W'(-r_s1_dx) : EXT_W'(r_s1_dx);
    assign abs_y = r_s1_dy[EXT_W-1] ? EXT_W'(-r_s1_dy) : EXT_W'(r_s1_dy);
    assign dbl_x = {abs_x[EXT_W-2:0], 1'b0};
    assign dbl_y = {abs_y[EXT_W-2:0], 1'b0};
    assign hit   = (dbl_x < r_s1_sx) && (dbl_y < r_s1_sy);

    // The stored bit, or the bit written back at the very edge this pair was read.
    assign was = r_fwd_hit ? r_fwd_bit : ram_rdata[0];

    always_comb begin
        case ({hit, was})
            2'b10:   ev = EV_ENTER;
            2'b11:   ev = EV_STAY;
            2'b01:   ev = EV_EXIT;
            default: ev = EV_NONE;
        endcase
    end

    // The clearing pass owns the write port; no pair is in flight meanwhile.
    assign ram_we    = clearing || s1_adv;
    assign ram_waddr = clearing ? r_clr_addr : r_s1_addr;
    assign ram_wdata = clearing ? 1'b0 : hit;

    apct_ram #(
        .WIDTH(1),
        .DEPTH(DEPTH)
    ) u_table (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_re   (in_accept),
        .i_raddr(in_addr),
        .o_rdata(ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_clr_addr <= '0;
            r_s1_valid <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_clr_addr <= n_clr_addr;
            if (in_accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_o_valid <= 1'b1;
            end else if (!i_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_addr <= in_addr;
            r_s1_dx   <= dx;
            r_s1_dy   <= dy;
            r_s1_sx   <= sx;
            r_s1_sy   <= sy;
            // The RAM returns the old bit when the pair ahead writes the same
            // entry at this edge, so the new bit is kept here instead.
            r_fwd_hit <= s1_adv && (r_s1_addr == in_addr);
            r_fwd_bit <= hit;
        end
        if (s1_adv) begin
            r_o_result.contact_event <= ev;
            r_o_result.overlapping   <= hit;
        end
    end

    assign o_valid  = r_o_valid;
    assign o_result = r_o_result;

endmodule

// ----- sv/apct_ram.sv -----
// Generic single-port-write, single-port-read RAM with a registered read.
`timescale 1ns / 1ps

module apct_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // A read and a write to the same address in one cycle return the old data.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- sv/apct_checker.sv -----
// Port-level checker for the box pair contact tracker, with its bind statement.
`timescale 1ns / 1ps

module apct_checker
    import apct_pkg::*;
(
    input logic    i_clk,
    input logic    i_rst_n,
    input logic    i_valid,
    input logic    o_stall,
    input t_pair   i_pair,
    input logic    o_valid,
    input logic    i_stall,
    input t_result o_result
);

    // A held result must not change while the receiver stalls.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_result))
        else $error("result changed while stalled");

    // Enter and stay are reported exactly when the boxes overlap now.
    a_event_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_result.contact_event == EV_ENTER ||
                      o_result.contact_event == EV_STAY) == o_result.overlapping))
        else $error("event disagrees with overlap flag");

    // A result that appears on an empty output came from an accepted pair.
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(i_valid && !o_stall, 2))
        else $error("result without an accepted pair");

endmodule

bind aabb_pair_contact_tracker apct_checker u_apct_checker (.*);
